// ===== sv/vtx4_pkg.sv =====
package vtx4_pkg;

  localparam int unsigned LANES = 4;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

endpackage

// ===== sv/vertex_transform_4x4.sv =====
// 4x4 matrix times 4-component vector, signed fixed point with FRAC_BITS fraction bits.
// The matrix is column-major: entry_index = column*4 + row, and output component r
// is the sum over k of m[k][r] * in_k. A load request writes one coefficient and
// yields no result; the new value is used by the very next transform request.
// After reset the matrix is the identity. Each product is exact, shifted right
// arithmetically by FRAC_BITS (rounds toward minus infinity), the four terms are
// summed without loss and saturated to DATA_WIDTH bits; overflow flags any
// saturated component. Throughput is one request per clock while the output is not
// stalled; a transform result passes through four register stages (split multiply,
// registered at acceptance; product merge and shift; pair add; final add and
// saturate). Stalls on the output back up stage by stage, filling bubbles first.
module vertex_transform_4x4 #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  vtx4_pkg::op_e                op_i,
  input  logic [3:0]                   entry_index_i,
  input  logic signed [DATA_WIDTH-1:0] coefficient_i,
  input  logic signed [DATA_WIDTH-1:0] in_x_i,
  input  logic signed [DATA_WIDTH-1:0] in_y_i,
  input  logic signed [DATA_WIDTH-1:0] in_z_i,
  input  logic signed [DATA_WIDTH-1:0] in_w_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] out_x_o,
  output logic signed [DATA_WIDTH-1:0] out_y_o,
  output logic signed [DATA_WIDTH-1:0] out_z_o,
  output logic signed [DATA_WIDTH-1:0] out_w_o,
  output logic                         overflow_o
);
  import vtx4_pkg::*;

  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned LOW = DW / 2;             // low part of the split operand
  localparam int unsigned HIW = DW - LOW;           // high part, signed
  localparam int unsigned PLW = DW + LOW + 1;
  localparam int unsigned PHW = DW + HIW;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned TW  = PW - FRAC_BITS;
  localparam int unsigned PRW = TW + 1;
  localparam int unsigned SW  = TW + 2;

  localparam logic [DW-1:0] ONE     = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [DW-1:0] mat_q [LANES][LANES];      // [column][row]
  logic signed [DW-1:0] vec   [LANES];

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc;

  logic signed [PLW-1:0] pl_d [LANES][LANES], pl_q [LANES][LANES];
  logic signed [PHW-1:0] ph_d [LANES][LANES], ph_q [LANES][LANES];
  logic signed [TW-1:0]  term_d [LANES][LANES], term_q [LANES][LANES];
  logic signed [PRW-1:0] pair_d [LANES][2], pair_q [LANES][2];
  logic signed [DW-1:0]  res_d [LANES], res_q [LANES];
  logic [LANES-1:0]      sat_d;
  logic                  ovf_q;

  assign vec[0] = in_x_i;
  assign vec[1] = in_y_i;
  assign vec[2] = in_z_i;
  assign vec[3] = in_w_i;

  // Each stage advances when it is empty or the next one moves.
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign in_acc     = in_valid_i && in_ready_o;

  // Coefficient store; a load lands before the next request samples it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < LANES; c++) begin
        for (int r = 0; r < LANES; r++) begin
          mat_q[c][r] <= (c == r) ? ONE : '0;
        end
      end
    end else if (in_acc && op_i == OP_LOAD) begin
      mat_q[entry_index_i[3:2]][entry_index_i[1:0]] <= coefficient_i;
    end
  end

  // Stage 1: split multiply, operand vector cut into a signed high and unsigned low part.
  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      for (int k = 0; k < LANES; k++) begin
        pl_d[r][k] = PLW'(mat_q[k][r]) * PLW'($signed({1'b0, vec[k][LOW-1:0]}));
        ph_d[r][k] = PHW'(mat_q[k][r]) * PHW'($signed(vec[k][DW-1:LOW]));
      end
    end
  end

  // Stage 2: merge partial products and drop the fraction bits.
  always_comb begin
    logic signed [PW-1:0] prod;
    prod = '0;
    for (int r = 0; r < LANES; r++) begin
      for (int k = 0; k < LANES; k++) begin
        prod = (PW'(ph_q[r][k]) <<< LOW) + PW'(pl_q[r][k]);
        term_d[r][k] = prod[PW-1:FRAC_BITS];
      end
    end
  end

  // Stage 3: pairwise sums.
  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      pair_d[r][0] = PRW'(term_q[r][0]) + PRW'(term_q[r][1]);
      pair_d[r][1] = PRW'(term_q[r][2]) + PRW'(term_q[r][3]);
    end
  end

  // Stage 4: final sum and saturation.
  always_comb begin
    logic signed [SW-1:0] s;
    logic [SW-DW:0]       top;
    s   = '0;
    top = '0;
    for (int r = 0; r < LANES; r++) begin
      s   = SW'(pair_q[r][0]) + SW'(pair_q[r][1]);
      top = s[SW-1:DW-1];
      if (&top || ~|top) begin
        res_d[r] = s[DW-1:0];
        sat_d[r] = 1'b0;
      end else begin
        res_d[r] = s[SW-1] ? SAT_MIN : SAT_MAX;
        sat_d[r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_acc && op_i == OP_XFORM;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
    end
    if (rdy2) term_q <= term_d;
    if (rdy3) pair_q <= pair_d;
    if (rdy4) begin
      res_q <= res_d;
      ovf_q <= |sat_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign out_w_o     = res_q[3];
  assign overflow_o  = ovf_q;

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      out_x_o == SAT_MAX || out_x_o == SAT_MIN || out_y_o == SAT_MAX ||
      out_y_o == SAT_MIN || out_z_o == SAT_MAX || out_z_o == SAT_MIN ||
      out_w_o == SAT_MAX || out_w_o == SAT_MIN)
    else $error("overflow flagged without a saturated component");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q && !v2_q && !v3_q && !v4_q |-> in_ready_o)
    else $error("empty pipeline refuses a request");

  a_xform_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && op_i == OP_XFORM |=> v1_q)
    else $error("accepted transform did not enter the pipeline");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && op_i == OP_LOAD |=> !v1_q)
    else $error("load request produced a pipeline entry");

endmodule

// ===== tb/vertex_transform_4x4_test.sv =====
module vertex_transform_4x4_test;
  import vtx4_pkg::*;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 60;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] w;
    logic                     ovf;
  } vertex_out_t;

  class xform_scoreboard;
    logic signed [DATA_W-1:0] coeff_m [16];
    vertex_out_t              pending_vertices [$];
    int                       mismatches;
    int                       loads_seen;
    int                       xforms_seen;
    int                       saturated_seen;

    function new();
      for (int i = 0; i < 16; i++) begin
        coeff_m[i] = (i % 5 == 0) ? (DATA_W'(1) << FRAC_W) : '0;
      end
      mismatches     = 0;
      loads_seen     = 0;
      xforms_seen    = 0;
      saturated_seen = 0;
    endfunction

    function int outstanding();
      return pending_vertices.size();
    endfunction

    function logic signed [DATA_W-1:0] clamp_q16(input longint acc, inout logic ovf);
      if (acc > longint'(32'sh7FFF_FFFF)) begin
        ovf = 1'b1;
        return 32'sh7FFF_FFFF;
      end
      if (acc < longint'(32'sh8000_0000)) begin
        ovf = 1'b1;
        return 32'sh8000_0000;
      end
      return acc[DATA_W-1:0];
    endfunction

    function void note_request(input op_e op, input logic [3:0] idx,
                               input logic signed [DATA_W-1:0] coef, x, y, z, w);
      logic signed [DATA_W-1:0] vin  [4];
      logic signed [DATA_W-1:0] comp [4];
      longint                   acc;
      logic                     ovf;
      vertex_out_t              res;
      if (op == OP_LOAD) begin
        coeff_m[idx] = coef;
        loads_seen++;
        return;
      end
      vin = '{x, y, z, w};
      ovf = 1'b0;
      // column-major: output row r takes m[k*4 + r] * in_k, each product floored
      for (int r = 0; r < 4; r++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          acc += (longint'(coeff_m[k*4 + r]) * longint'(vin[k])) >>> FRAC_W;
        end
        comp[r] = clamp_q16(acc, ovf);
      end
      res.x   = comp[0];
      res.y   = comp[1];
      res.z   = comp[2];
      res.w   = comp[3];
      res.ovf = ovf;
      if (ovf) saturated_seen++;
      xforms_seen++;
      pending_vertices.push_back(res);
    endfunction

    function void check_result(input logic signed [DATA_W-1:0] x, y, z, w,
                               input logic ovf);
      vertex_out_t want;
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result with no pending request: x=%h y=%h z=%h w=%h ovf=%b",
                   x, y, z, w, ovf);
        end
        return;
      end
      want = pending_vertices.pop_front();
      if (x !== want.x || y !== want.y || z !== want.z || w !== want.w ||
          ovf !== want.ovf) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected x=%h y=%h z=%h w=%h ovf=%b", want.x, want.y,
                   want.z, want.w, want.ovf);
          $display("          got      x=%h y=%h z=%h w=%h ovf=%b", x, y, z, w, ovf);
        end
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  op_e                      op_i;
  logic [3:0]               entry_index_i;
  logic signed [DATA_W-1:0] coefficient_i;
  logic signed [DATA_W-1:0] in_x_i;
  logic signed [DATA_W-1:0] in_y_i;
  logic signed [DATA_W-1:0] in_z_i;
  logic signed [DATA_W-1:0] in_w_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] out_x_o;
  logic signed [DATA_W-1:0] out_y_o;
  logic signed [DATA_W-1:0] out_z_o;
  logic signed [DATA_W-1:0] out_w_o;
  logic                     overflow_o;

  xform_scoreboard sb;
  logic            hold_out_req;
  logic            calm_phase;
  int unsigned     cycle_count;

  vertex_transform_4x4 #(
    .DATA_WIDTH(DATA_W),
    .FRAC_BITS (FRAC_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .entry_index_i(entry_index_i),
    .coefficient_i(coefficient_i),
    .in_x_i       (in_x_i),
    .in_y_i       (in_y_i),
    .in_z_i       (in_z_i),
    .in_w_i       (in_w_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_w_o      (out_w_o),
    .overflow_o   (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(op_i, entry_index_i, coefficient_i, in_x_i, in_y_i, in_z_i, in_w_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_x_o, out_y_o, out_z_o, out_w_o, overflow_o);
      end
    end
  end

  // Result side: short random stalls, or one long hold-off when asked.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_out_req) begin
        hold_out_req <= 1'b0;
        out_ready_i  <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] rand_q16();
    int v;
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(0, 5))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sh0000_0000;
          3:       return 32'sh0001_0000;
          4:       return 32'shFFFF_0000;
          default: return 32'shFFFF_FFFF;
        endcase
      end
      default: begin
        // mostly values within +/-32.0 so that sums stay in range
        v = int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        return v;
      end
    endcase
  endfunction

  task automatic send_req(input op_e op, input logic [3:0] idx,
                          input logic signed [DATA_W-1:0] coef, x, y, z, w);
    in_valid_i    <= 1'b1;
    op_i          <= op;
    entry_index_i <= idx;
    coefficient_i <= coef;
    in_x_i        <= x;
    in_y_i        <= y;
    in_z_i        <= z;
    in_w_i        <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_load(input logic [3:0] idx, input logic signed [DATA_W-1:0] coef);
    send_req(OP_LOAD, idx, coef, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic send_xform(input logic signed [DATA_W-1:0] x, y, z, w);
    send_req(OP_XFORM, 4'($urandom()), $urandom(), x, y, z, w);
  endtask

  task automatic pause_input();
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_req();
    if ($urandom_range(0, 3) == 0) begin
      send_load(4'($urandom_range(0, 15)), rand_q16());
    end else begin
      send_xform(rand_q16(), rand_q16(), rand_q16(), rand_q16());
    end
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      // now and then load a whole fresh matrix, then stream vectors through it
      if ($urandom_range(0, 19) == 0) begin
        for (int e = 0; e < 16; e++) begin
          send_load(4'(e), rand_q16());
          pause_input();
        end
      end else begin
        send_random_req();
        pause_input();
      end
    end
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_LOAD;
    entry_index_i = '0;
    coefficient_i = '0;
    in_x_i        = '0;
    in_y_i        = '0;
    in_z_i        = '0;
    in_w_i        = '0;
    out_ready_i   = 1'b0;
    hold_out_req  = 1'b0;
    calm_phase    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity matrix with extreme components
    send_xform(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'sh0001_0000);
    send_xform(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'sh0000_0001);
    // w feeds the last term of x; the load must reach the very next transform
    send_load(4'd12, 32'sh0001_0000);
    send_xform(32'sh0003_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0002_0000);
    // saturate high and low
    send_load(4'd0, 32'sh7FFF_FFFF);
    send_xform(32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0000);
    send_xform(32'sh8000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
    send_load(4'd15, 32'sh8000_0000);
    send_xform(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh7FFF_FFFF);
    send_load(4'd0, 32'sh8000_0000);
    send_xform(32'sh8000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
    // shifted product rounds toward minus infinity
    send_load(4'd5, 32'sh0000_0001);
    send_xform(32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0000, 32'sh0000_0000);
    send_xform(32'sh0000_0000, 32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000);
    send_xform(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
    send_load(4'd3, 32'shFFFF_0000);
    send_xform(32'sh0005_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
    // back to identity
    send_load(4'd0, 32'sh0001_0000);
    send_load(4'd5, 32'sh0001_0000);
    send_load(4'd15, 32'sh0001_0000);
    send_load(4'd12, 32'sh0000_0000);
    send_load(4'd3, 32'sh0000_0000);

    run_random(120);

    // hold the result side off and keep offering until the input stalls
    hold_out_req <= 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_xform(rand_q16(), rand_q16(), rand_q16(), rand_q16());
    end

    // drain completely before going on
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);

    run_random(120);

    calm_phase <= 1'b1;
    run_random(50);

    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d coefficient loads and %0d vector transforms in %0d cycles,",
             sb.loads_seen, sb.xforms_seen, cycle_count);
    $display("%0d transforms saturated, %0d mismatches.", sb.saturated_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
